// File: rtl/pch_pkg.sv
`timescale 1ns / 1ps

package pch_pkg;

  // Default sizes of the point store and of one coordinate.
  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;

  // Smallest number of points, and of hull vertices, that form a hull.
  localparam int MIN_HULL = 3;

  // Depth of the command queue between front and back.
  localparam int CMD_DEPTH = 2;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_FEW = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Kind of job the front hands to the back.
  typedef enum logic [1:0] {
    CMD_HULL    = 2'd0,
    CMD_ERR_FEW = 2'd1,
    CMD_ERR_OVF = 2'd2
  } cmd_kind_t;

endpackage

// File: rtl/pch_ram.sv
`timescale 1ns / 1ps

module pch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; the read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pch_cmd_fifo.sv
`timescale 1ns / 1ps

module pch_cmd_fifo #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp] <= din;
    end
  end

  // Pointers wrap explicitly so that any depth works.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop && !empty) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        cnt <= cnt + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pch_front.sv
`timescale 1ns / 1ps

module pch_front #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16,
  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNW = $clog2(MAX_POINTS + 1),
  localparam int IDW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [IDW-1:0]             s_tdata,   // coord_x, coord_y, zero fill
  input  logic                       s_tlast,
  output logic                       st_we,
  output logic [IW-1:0]              st_waddr,
  output logic [2*COORD_WIDTH-1:0]   st_wdata,
  output logic                       cmd_push,
  output pch_pkg::cmd_kind_t         cmd_kind,
  output logic [CNW-1:0]             cmd_count,
  input  logic                       cmd_full,
  input  logic                       release_store
);

  import pch_pkg::*;

  logic           accept;
  logic           room;
  logic [CNW-1:0] count;
  logic [CNW-1:0] count_next;
  logic           ovf;
  logic           ovf_next;
  logic           locked;

  // The store stays with the back while it works on a hull.
  assign s_tready = !locked && !cmd_full;
  assign accept   = s_tvalid && s_tready;
  assign room     = (count < CNW'(MAX_POINTS));

  assign st_we    = accept && room;
  assign st_waddr = count[IW-1:0];
  assign st_wdata = s_tdata[2*COORD_WIDTH-1:0];

  assign count_next = room ? count + 1'b1 : count;
  assign ovf_next   = ovf || !room;

  // Classify the set when its last word arrives.
  assign cmd_push  = accept && s_tlast;
  assign cmd_count = count_next;
  always_comb begin
    if (ovf_next) begin
      cmd_kind = CMD_ERR_OVF;
    end else if (count_next < CNW'(MIN_HULL)) begin
      cmd_kind = CMD_ERR_FEW;
    end else begin
      cmd_kind = CMD_HULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      locked <= 1'b0;
    end else begin
      if (release_store) begin
        locked <= 1'b0;
      end
      if (accept) begin
        if (s_tlast) begin
          count <= '0;
          ovf   <= 1'b0;
          if (cmd_kind == CMD_HULL) begin
            locked <= 1'b1;
          end
        end else begin
          count <= count_next;
          ovf   <= ovf_next;
        end
      end
    end
  end

endmodule

// File: rtl/pch_back.sv
`timescale 1ns / 1ps

module pch_back #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16,
  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNW = $clog2(MAX_POINTS + 1),
  localparam int SAW = $clog2(2 * MAX_POINTS),
  localparam int SW  = $clog2(2 * MAX_POINTS + 1),
  localparam int ODW = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int PTW = 2 * COORD_WIDTH,
  localparam int DW  = COORD_WIDTH + 1,
  localparam int PRW = 2 * DW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fr_we,
  input  logic [IW-1:0]        fr_waddr,
  input  logic [PTW-1:0]       fr_wdata,
  input  logic [CNW+1:0]       cmd_data,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output logic                 release_store,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [ODW-1:0]       m_tdata,   // vertex_x, vertex_y, zero fill
  output logic                 m_tlast,
  output logic [1:0]           m_tuser    // status
);

  import pch_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE     = 22'd1 << 0,
    S_ERR      = 22'd1 << 1,
    S_SORT_I   = 22'd1 << 2,
    S_SORT_KEY = 22'd1 << 3,
    S_SORT_J   = 22'd1 << 4,
    S_SORT_CMP = 22'd1 << 5,
    S_CH0      = 22'd1 << 6,
    S_CH1      = 22'd1 << 7,
    S_PUSH_U   = 22'd1 << 8,
    S_LINIT    = 22'd1 << 9,
    S_PUSH_L   = 22'd1 << 10,
    S_TRIM     = 22'd1 << 11,
    S_F_STK    = 22'd1 << 12,
    S_F_STK_W  = 22'd1 << 13,
    S_F_PT     = 22'd1 << 14,
    S_X1       = 22'd1 << 15,
    S_X2       = 22'd1 << 16,
    S_X3       = 22'd1 << 17,
    S_DONE     = 22'd1 << 18,
    S_E_STK    = 22'd1 << 19,
    S_E_W      = 22'd1 << 20,
    S_E_PT     = 22'd1 << 21
  } state_t;

  state_t state;

  cmd_kind_t      cmd_kind;
  logic [CNW-1:0] cmd_count;

  logic [CNW-1:0] n;
  logic [CNW-1:0] i;
  logic [CNW-1:0] j;
  logic [CNW-1:0] q;
  logic [PTW-1:0] key;
  logic [SW-1:0]  top;
  logic [SW-1:0]  base;
  logic [SW-1:0]  upper;
  logic [SW-1:0]  e;
  logic [SW-1:0]  k;
  logic [1:0]     k3;
  logic [IW-1:0]  cidx;
  logic           lower;
  logic [1:0]     err_code;
  logic           err_rel;

  logic signed [COORD_WIDTH-1:0] pt_x [3];
  logic signed [COORD_WIDTH-1:0] pt_y [3];
  logic signed [DW-1:0]          dx1;
  logic signed [DW-1:0]          dy1;
  logic signed [DW-1:0]          dx2;
  logic signed [DW-1:0]          dy2;
  logic signed [PRW-1:0]         prod_p;
  logic signed [PRW-1:0]         prod_q;

  logic           st_we_b;
  logic           st_we;
  logic [IW-1:0]  st_waddr_b;
  logic [IW-1:0]  st_waddr;
  logic [PTW-1:0] st_wdata_b;
  logic [PTW-1:0] st_wdata;
  logic           st_re;
  logic [IW-1:0]  st_raddr;
  logic [PTW-1:0] st_q;

  logic           sk_we;
  logic [SAW-1:0] sk_waddr;
  logic [IW-1:0]  sk_wdata;
  logic           sk_re;
  logic [SAW-1:0] sk_raddr;
  logic [IW-1:0]  sk_q;

  logic           out_free;
  logic           out_load;
  logic           rel_now;
  logic           key_first;
  logic [CNW-1:0] j_m1;
  logic [CNW-1:0] n_m1;
  logic [CNW-1:0] n_m2;
  logic [CNW-1:0] q_m1;
  logic [SW-1:0]  top_p1;
  logic [SW-1:0]  top_m2;
  logic [SW-1:0]  fetch_addr;

  assign cmd_kind  = cmd_kind_t'(cmd_data[CNW+1:CNW]);
  assign cmd_count = cmd_data[CNW-1:0];
  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;
  assign out_free  = !m_tvalid || m_tready;

  // A new output word loads in the error and emission steps once the register is free.
  assign out_load = ((state == S_ERR) || (state == S_E_PT)) && out_free;

  // The store goes back to the front after the last hull word or a late error word.
  assign rel_now = ((state == S_ERR) && out_free && err_rel) ||
                   ((state == S_E_STK) && (e == top - 1'b1));

  assign j_m1       = j - 1'b1;
  assign n_m1       = n - 1'b1;
  assign n_m2       = n - CNW'(2);
  assign q_m1       = q - 1'b1;
  assign top_p1     = top + 1'b1;
  assign top_m2     = top - SW'(2);
  assign fetch_addr = top - SW'(3) + SW'(k3);

  // Sort order: x ascending, and for equal x, y descending.
  assign key_first =
    ($signed(key[COORD_WIDTH-1:0]) < $signed(st_q[COORD_WIDTH-1:0])) ||
    (($signed(key[COORD_WIDTH-1:0]) == $signed(st_q[COORD_WIDTH-1:0])) &&
     ($signed(key[PTW-1:COORD_WIDTH]) > $signed(st_q[PTW-1:COORD_WIDTH])));

  // Point store: loaded by the front, sorted in place and read by the back.
  assign st_we    = fr_we || st_we_b;
  assign st_waddr = st_we_b ? st_waddr_b : fr_waddr;
  assign st_wdata = st_we_b ? st_wdata_b : fr_wdata;

  pch_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_q)
  );

  pch_ram #(.WIDTH(IW), .DEPTH(2 * MAX_POINTS)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_q)
  );

  // Memory controls of each sequencer step.
  always_comb begin
    st_we_b    = 1'b0;
    st_waddr_b = j[IW-1:0];
    st_wdata_b = key;
    st_re      = 1'b0;
    st_raddr   = i[IW-1:0];
    sk_we      = 1'b0;
    sk_waddr   = top[SAW-1:0];
    sk_wdata   = q[IW-1:0];
    sk_re      = 1'b0;
    sk_raddr   = e[SAW-1:0];
    unique case (state)
      S_SORT_I: begin
        st_re = (i != n);
      end
      S_SORT_J: begin
        if (j == '0) begin
          st_we_b = 1'b1;
        end else begin
          st_re    = 1'b1;
          st_raddr = j_m1[IW-1:0];
        end
      end
      S_SORT_CMP: begin
        st_we_b    = 1'b1;
        st_wdata_b = key_first ? st_q : key;
      end
      S_CH0: begin
        sk_we    = 1'b1;
        sk_waddr = '0;
        sk_wdata = '0;
      end
      S_CH1: begin
        sk_we    = 1'b1;
        sk_waddr = SAW'(1);
        sk_wdata = IW'(1);
      end
      S_PUSH_U: begin
        sk_we = 1'b1;
        if (q == n) begin
          sk_wdata = n_m1[IW-1:0];
        end
      end
      S_LINIT: begin
        sk_we    = 1'b1;
        sk_waddr = top_p1[SAW-1:0];
        sk_wdata = n_m2[IW-1:0];
      end
      S_PUSH_L: begin
        sk_we    = (q != '0);
        sk_wdata = q_m1[IW-1:0];
      end
      S_F_STK: begin
        sk_re    = 1'b1;
        sk_raddr = fetch_addr[SAW-1:0];
      end
      S_F_STK_W: begin
        st_re    = 1'b1;
        st_raddr = sk_q;
      end
      S_X3: begin
        sk_we    = (prod_p >= prod_q);
        sk_waddr = top_m2[SAW-1:0];
        sk_wdata = cidx;
      end
      S_E_STK: begin
        sk_re = (e != top - 1'b1) && (e != upper);
      end
      S_E_W: begin
        st_re    = 1'b1;
        st_raddr = sk_q;
      end
      default: begin
      end
    endcase
  end

  // Job sequencer: sort, upper chain, lower chain, emission, or a status word for an error set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      release_store <= 1'b0;
      top           <= '0;
      base          <= '0;
    end else begin
      release_store <= rel_now;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            n <= cmd_count;
            unique case (cmd_kind)
              CMD_HULL: begin
                i     <= CNW'(1);
                state <= S_SORT_I;
              end
              CMD_ERR_FEW: begin
                err_code <= ST_FEW;
                err_rel  <= 1'b0;
                state    <= S_ERR;
              end
              CMD_ERR_OVF: begin
                err_code <= ST_OVF;
                err_rel  <= 1'b0;
                state    <= S_ERR;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ERR: begin
          if (out_free) begin
            m_tdata <= '0;
            m_tlast <= 1'b1;
            m_tuser <= err_code;
            state   <= S_IDLE;
          end
        end
        S_SORT_I: begin
          state <= (i == n) ? S_CH0 : S_SORT_KEY;
        end
        S_SORT_KEY: begin
          key   <= st_q;
          j     <= i;
          state <= S_SORT_J;
        end
        S_SORT_J: begin
          if (j == '0) begin
            i     <= i + 1'b1;
            state <= S_SORT_I;
          end else begin
            state <= S_SORT_CMP;
          end
        end
        S_SORT_CMP: begin
          if (key_first) begin
            j     <= j_m1;
            state <= S_SORT_J;
          end else begin
            i     <= i + 1'b1;
            state <= S_SORT_I;
          end
        end
        S_CH0: begin
          state <= S_CH1;
        end
        S_CH1: begin
          top   <= SW'(2);
          base  <= '0;
          q     <= CNW'(2);
          lower <= 1'b0;
          state <= S_PUSH_U;
        end
        S_PUSH_U: begin
          if (q == n) begin
            upper <= top;
            state <= S_LINIT;
          end else begin
            top   <= top_p1;
            q     <= q + 1'b1;
            state <= S_TRIM;
          end
        end
        S_LINIT: begin
          top   <= top + SW'(2);
          base  <= top;
          q     <= n_m2;
          lower <= 1'b1;
          state <= S_PUSH_L;
        end
        S_PUSH_L: begin
          if (q == '0) begin
            state <= S_DONE;
          end else begin
            top   <= top_p1;
            q     <= q_m1;
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (top - base >= SW'(3)) begin
            k3    <= '0;
            state <= S_F_STK;
          end else begin
            state <= lower ? S_PUSH_L : S_PUSH_U;
          end
        end
        S_F_STK: begin
          state <= S_F_STK_W;
        end
        S_F_STK_W: begin
          if (k3 == 2'd2) begin
            cidx <= sk_q;
          end
          state <= S_F_PT;
        end
        S_F_PT: begin
          pt_x[k3] <= st_q[COORD_WIDTH-1:0];
          pt_y[k3] <= st_q[PTW-1:COORD_WIDTH];
          if (k3 == 2'd2) begin
            state <= S_X1;
          end else begin
            k3    <= k3 + 1'b1;
            state <= S_F_STK;
          end
        end
        S_X1: begin
          dx1   <= DW'(pt_x[1]) - DW'(pt_x[0]);
          dy1   <= DW'(pt_y[1]) - DW'(pt_y[0]);
          dx2   <= DW'(pt_x[2]) - DW'(pt_x[0]);
          dy2   <= DW'(pt_y[2]) - DW'(pt_y[0]);
          state <= S_X2;
        end
        S_X2: begin
          prod_p <= dx1 * dy2;
          prod_q <= dy1 * dx2;
          state  <= S_X3;
        end
        S_X3: begin
          // The middle point goes while the turn is not strictly clockwise.
          if (prod_p >= prod_q) begin
            top   <= top - 1'b1;
            state <= S_TRIM;
          end else begin
            state <= lower ? S_PUSH_L : S_PUSH_U;
          end
        end
        S_DONE: begin
          if ((top < SW'(MIN_HULL + 2)) || (top > SW'(MAX_POINTS + 2))) begin
            err_code <= ST_FEW;
            err_rel  <= 1'b1;
            state    <= S_ERR;
          end else begin
            e     <= '0;
            k     <= '0;
            state <= S_E_STK;
          end
        end
        S_E_STK: begin
          if (e == top - 1'b1) begin
            state <= S_IDLE;
          end else if (e == upper) begin
            e <= e + 1'b1;
          end else begin
            state <= S_E_W;
          end
        end
        S_E_W: begin
          state <= S_E_PT;
        end
        S_E_PT: begin
          if (out_free) begin
            m_tdata <= ODW'(st_q);
            m_tlast <= (k == top - SW'(3));
            m_tuser <= ST_OK;
            k       <= k + 1'b1;
            e       <= e + 1'b1;
            state   <= S_E_STK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    top <= SW'(2 * MAX_POINTS))
    else $error("chain stack pointer beyond stack depth");

  a_trim_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRIM) |-> (top >= base + SW'(2)))
    else $error("chain shorter than its two seed entries");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> m_tlast)
    else $error("error word not marked as final");

  a_store_clash: assert property (@(posedge clk) disable iff (rst)
    fr_we |-> !st_we_b)
    else $error("front wrote the store while the back sorts it");
`endif

endmodule

// File: rtl/planar_convex_hull_unit.sv
`timescale 1ns / 1ps

// Convex hull of a set of 2D integer points.
// Input channel s_*: one point per word, s_tdata = {coord_y, coord_x}, s_tlast on the
// final point of a set. Output channel m_*: the hull vertices in order (upper chain
// left to right, then lower chain right to left), m_tdata = {vertex_y, vertex_x},
// m_tuser = status, m_tlast on the final vertex. A set with an overflowing count or
// fewer than three points, or a degenerate hull, gives one word of zeros with status.
// Points load at one per cycle while s_tready is high. After the last point the back
// sorts the store in place by insertion (a read and a compare state per comparison, one
// read port on the store), then runs both chains; each turn test rests on three serial
// stack and store reads and the two-stage cross product, and each vertex is emitted
// through a stack read, a store read and an output load. Up to about 4*n turn tests run
// for n points. While a hull is in work the input stalls; error sets pass through a
// two-entry command queue. A stalled receiver holds the output word and pauses the
// emission. Reset empties the queue, clears the point count and drops any output word.
module planar_convex_hull_unit #(
  parameter int MAX_POINTS  = pch_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH = pch_pkg::COORD_WIDTH_DEF,
  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNW = $clog2(MAX_POINTS + 1),
  localparam int DBW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [DBW-1:0] s_tdata,   // coord_x, coord_y, zero fill
  input  logic           s_tlast,   // last_point
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [DBW-1:0] m_tdata,   // vertex_x, vertex_y, zero fill
  output logic           m_tlast,   // last_vertex
  output logic [1:0]     m_tuser    // status
);

  import pch_pkg::*;

  logic                   fr_we;
  logic [IW-1:0]          fr_waddr;
  logic [2*COORD_WIDTH-1:0] fr_wdata;
  logic                   cmd_push;
  cmd_kind_t              cmd_kind;
  logic [CNW-1:0]         cmd_count;
  logic                   cmd_full;
  logic                   cmd_empty;
  logic                   cmd_pop;
  logic [CNW+1:0]         cmd_dout;
  logic                   release_store;

  pch_front #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .st_we         (fr_we),
    .st_waddr      (fr_waddr),
    .st_wdata      (fr_wdata),
    .cmd_push      (cmd_push),
    .cmd_kind      (cmd_kind),
    .cmd_count     (cmd_count),
    .cmd_full      (cmd_full),
    .release_store (release_store)
  );

  pch_cmd_fifo #(.WIDTH(CNW + 2), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   ({cmd_kind, cmd_count}),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  pch_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .fr_we         (fr_we),
    .fr_waddr      (fr_waddr),
    .fr_wdata      (fr_wdata),
    .cmd_data      (cmd_dout),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .release_store (release_store),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser)
  );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pch_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               tl;
    logic [1:0]         st;
  } vertex_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  planar_convex_hull_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hull predictor state: points of the set being loaded.
  logic signed [15:0] pts_x [NPTS];
  logic signed [15:0] pts_y [NPTS];
  int      pts_n = 0;
  bit      pts_ovf = 0;
  vertex_t hull_q[$];
  int      errors = 0;
  int      words_out = 0;
  int      sets_done = 0;
  bit      stim_done = 0;

  // Sign of cross(b - a, c - a); 64-bit math is exact for 16-bit inputs.
  function automatic int cross_sign(int a, int b, int c);
    longint dx1, dy1, dx2, dy2, cr;
    dx1 = longint'(pts_x[b]) - pts_x[a];
    dy1 = longint'(pts_y[b]) - pts_y[a];
    dx2 = longint'(pts_x[c]) - pts_x[a];
    dy2 = longint'(pts_y[c]) - pts_y[a];
    cr = dx1 * dy2 - dy1 * dx2;
    return (cr > 0) ? 1 : (cr < 0) ? -1 : 0;
  endfunction

  function automatic void push_error(logic [1:0] code);
    vertex_t v;
    v.x = '0; v.y = '0; v.tl = 1'b1; v.st = code;
    hull_q = {hull_q, v};
  endfunction

  // Take one point; on the last point of a set compute the expected hull.
  function automatic void predict_hull(logic signed [15:0] x, logic signed [15:0] y,
                                       bit tl);
    int n, upper, lower_end, total, k, j;
    int chain[$];
    logic signed [15:0] tx, ty;
    vertex_t v;
    if (pts_n < NPTS) begin
      pts_x[pts_n] = x;
      pts_y[pts_n] = y;
      pts_n++;
    end else begin
      pts_ovf = 1;
    end
    if (!tl) return;
    n = pts_n;
    pts_n = 0;
    sets_done++;
    if (pts_ovf) begin
      pts_ovf = 0;
      push_error(ST_OVF);
      return;
    end
    if (n < MIN_HULL) begin
      push_error(ST_FEW);
      return;
    end
    // Insertion sort: x ascending, then y descending.
    for (int i = 1; i < n; i++) begin
      j = i;
      while (j > 0 && (pts_x[j] < pts_x[j-1] ||
                       (pts_x[j] == pts_x[j-1] && pts_y[j] > pts_y[j-1]))) begin
        tx = pts_x[j]; ty = pts_y[j];
        pts_x[j] = pts_x[j-1]; pts_y[j] = pts_y[j-1];
        pts_x[j-1] = tx; pts_y[j-1] = ty;
        j--;
      end
    end
    // Upper chain left to right.
    chain = {chain, 0};
    chain = {chain, 1};
    for (int i = 2; i < n; i++) begin
      chain = {chain, i};
      while (chain.size() >= 3 && cross_sign(chain[chain.size()-3], chain[chain.size()-2],
                                             chain[chain.size()-1]) >= 0)
        chain.delete(chain.size() - 2);
    end
    upper = chain.size();
    // Lower chain right to left.
    chain = {chain, n - 1};
    chain = {chain, n - 2};
    for (int i = n - 2; i > 0; i--) begin
      chain = {chain, i - 1};
      while (chain.size() - upper >= 3 &&
             cross_sign(chain[chain.size()-3], chain[chain.size()-2],
                        chain[chain.size()-1]) >= 0)
        chain.delete(chain.size() - 2);
    end
    lower_end = chain.size();
    total = upper + (lower_end - upper - 2);
    if (total < MIN_HULL || total > NPTS) begin
      push_error(ST_FEW);
      return;
    end
    k = 0;
    for (int i = 0; i < lower_end - 1; i++) begin
      if (i == upper) continue;
      v.x = pts_x[chain[i]];
      v.y = pts_y[chain[i]];
      v.tl = (k + 1 == total);
      v.st = ST_OK;
      hull_q = {hull_q, v};
      k++;
    end
  endfunction

  // Directed sets, one row per point; tl closes a set. Rows with typed set carry
  // the status of the single error word that the set gives.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 tl;
    bit                 typed;
    logic [1:0]         st;
  } point_row_t;

  point_row_t directed_rows[] = '{
    // One point: too few.
    '{16'sh7fff, 16'sh8000, 1, 1, ST_FEW},
    // Two points: too few.
    '{0, 0, 0, 0, ST_OK}, '{5, 5, 1, 1, ST_FEW},
    // Collinear: degenerate.
    '{0, 0, 0, 0, ST_OK}, '{1, 1, 0, 0, ST_OK}, '{2, 2, 1, 1, ST_FEW},
    // Coincident: degenerate.
    '{7, 7, 0, 0, ST_OK}, '{7, 7, 0, 0, ST_OK}, '{7, 7, 1, 1, ST_FEW},
    // Extreme square with an interior point.
    '{-32768, -32768, 0, 0, ST_OK}, '{32767, 32767, 0, 0, ST_OK},
    '{-32768, 32767, 0, 0, ST_OK}, '{32767, -32768, 0, 0, ST_OK},
    '{0, 0, 1, 0, ST_OK},
    // Equal x columns.
    '{3, 1, 0, 0, ST_OK}, '{3, 9, 0, 0, ST_OK}, '{3, -4, 0, 0, ST_OK},
    '{-2, 0, 0, 0, ST_OK}, '{8, 2, 1, 0, ST_OK},
    // Triangle, input not in sorted order.
    '{10, -1, 0, 0, ST_OK}, '{-10, -1, 0, 0, ST_OK}, '{0, 20, 1, 0, ST_OK}
  };

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit tl);
    // Random idle gaps, mostly short.
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tlast <= tl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_hull(x, y, tl);
    @(negedge clk);
  endtask

  // Drive a whole set of random points.
  task automatic send_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_point(16'($urandom_range(0, 2 * span) - span),
                 16'($urandom_range(0, 2 * span) - span), i == n - 1);
  endtask

  initial begin
    int items, n, span;
    vertex_t typed_v;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].tl);
      if (directed_rows[i].typed) begin
        typed_v = hull_q[hull_q.size() - 1];
        if (typed_v.x !== 16'sd0 || typed_v.y !== 16'sd0 || typed_v.tl !== 1'b1 ||
            typed_v.st !== directed_rows[i].st) begin
          errors++;
          $display("%0t: expected x=0 y=0 last=1 status=%0d, got x=%0d y=%0d last=%0b status=%0d",
                   $time, directed_rows[i].st, typed_v.x, typed_v.y, typed_v.tl,
                   typed_v.st);
        end
      end
    end
    // Overflow: one more point than the store holds.
    send_set(NPTS + 1, 100);
    items = directed_rows.size() + NPTS + 1;
    while (items < 280) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(1, 2);
        1: n = NPTS;
        default: n = $urandom_range(3, 12);
      endcase
      span = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(1, 20);
      send_set(n, span);
      items += n;
    end
    s_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Output stall, with stretches of full throughput.
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if ($urandom_range(0, 15) == 0) m_tready <= 1'b0;
    else if (!m_tready && $urandom_range(0, 5) == 0) m_tready <= 1'b1;
    else if ($urandom_range(0, 60) == 0) m_tready <= 1'b0;
    else m_tready <= m_tready | ($urandom_range(0, 1) == 0);
  end

  // Compare each output word with the oldest expected vertex.
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (hull_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word x=%0d y=%0d last=%0b status=%0d", $time,
                 $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast, m_tuser);
      end else begin
        want = hull_q.pop_front();
        if (m_tdata[15:0] !== want.x || m_tdata[31:16] !== want.y ||
            m_tlast !== want.tl || m_tuser !== want.st) begin
          errors++;
          $display("%0t: expected x=%0d y=%0d last=%0b status=%0d, got x=%0d y=%0d last=%0b status=%0d",
                   $time, want.x, want.y, want.tl, want.st, $signed(m_tdata[15:0]),
                   $signed(m_tdata[31:16]), m_tlast, m_tuser);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (hull_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d point sets, %0d result words checked.", sets_done, words_out);
    if (errors == 0 && hull_q.size() == 0) $display("PASS planar_convex_hull_unit");
    else $display("FAIL planar_convex_hull_unit");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL planar_convex_hull_unit");
    $finish;
  end

endmodule
